>>> rtl/uer_pkg.sv
// Package: shared types and constants of the ultrasonic echo ranger.
`default_nettype none
package uer_pkg;

    localparam int unsigned TRIG_W  = 16;
    localparam int unsigned TICK_W  = 32;
    localparam int unsigned SCALE_W = 24;
    localparam int unsigned DIST_W  = 20;
    localparam int unsigned SHOW_W  = 32;
    localparam int unsigned PAD_W   = 48;
    localparam int unsigned CFG_AW  = 2;
    localparam int unsigned CFG_DW  = 32;

    localparam logic [CFG_AW-1:0] CFG_TRIGGER_TICKS = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_TIMEOUT_TICKS = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_SCALE_FACTOR  = 2'd2;

    localparam logic [TRIG_W-1:0]  TRIGGER_TICKS_RST = 16'd3000;
    localparam logic [TICK_W-1:0]  TIMEOUT_TICKS_RST = 32'd3000000;
    localparam logic [SCALE_W-1:0] SCALE_FACTOR_RST  = 24'd730144;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2,
        PH_MEAS = 2'd3
    } uer_phase_t;

    typedef struct packed {
        logic mode;
        logic echo_level;
    } uer_item_t;

    typedef struct packed {
        logic              trigger_level;
        logic              busy_res;
        logic              done_res;
        logic              timed_out;
        logic [SHOW_W-1:0] echo_ticks;
        logic [DIST_W-1:0] distance_q8;
    } uer_result_t;

    // per-tick status bits passed from front to back
    typedef struct packed {
        logic trigger_level;
        logic busy_res;
        logic done_res;
        logic timed_out;
    } uer_flags_t;

endpackage
`default_nettype wire

>>> rtl/uer_front.sv
// Front end: trigger / wait / measure sequencer, one tick word per accepted cycle.
`default_nettype none
module uer_front #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire uer_pkg::uer_item_t            item,
    input  wire logic [uer_pkg::TRIG_W-1:0]    trigger_ticks,
    input  wire logic [uer_pkg::TICK_W-1:0]    timeout_ticks,
    output uer_pkg::uer_flags_t                flags,
    output logic [COUNT_WIDTH-1:0]             ticks
);
    import uer_pkg::*;

    uer_phase_t             phase_reg, phase_next;
    logic [TICK_W-1:0]      tick_reg, tick_next;
    logic [COUNT_WIDTH-1:0] echo_cnt_reg, echo_cnt_next;
    logic                   echo_prev_reg;
    logic [COUNT_WIDTH-1:0] res_ticks_reg, res_ticks_next;
    logic                   res_to_reg, res_to_next;

    logic              rise, fall, trig, done, finished;
    logic [TRIG_W-1:0] tlen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            echo_cnt_reg  <= '0;
            echo_prev_reg <= 1'b0;
            res_ticks_reg <= '0;
            res_to_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            echo_cnt_reg  <= echo_cnt_next;
            echo_prev_reg <= item.echo_level;
            res_ticks_reg <= res_ticks_next;
            res_to_reg    <= res_to_next;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        echo_cnt_next  = echo_cnt_reg;
        res_ticks_next = res_ticks_reg;
        res_to_next    = res_to_reg;
        trig           = 1'b0;
        done           = 1'b0;
        finished       = 1'b0;
        tlen           = (trigger_ticks == '0) ? TRIG_W'(1) : trigger_ticks;
        rise           = item.echo_level & ~echo_prev_reg;
        fall           = ~item.echo_level & echo_prev_reg;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (item.mode)
                begin
                    phase_next    = PH_TRIG;
                    tick_next     = TICK_W'(1);
                    echo_cnt_next = '0;
                    trig          = 1'b1;
                end
            end
            PH_TRIG:
            begin
                if (tick_reg >= TICK_W'(tlen))
                begin
                    phase_next = PH_WAIT;
                    tick_next  = '0;
                end
                else
                begin
                    tick_next = tick_reg + TICK_W'(1);
                    trig      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (phase_next == PH_WAIT || phase_next == PH_MEAS)
        begin
            if (phase_next == PH_WAIT)
            begin
                if (rise)
                begin
                    phase_next    = PH_MEAS;
                    echo_cnt_next = COUNT_WIDTH'(1);
                end
            end
            else if (fall)
            begin
                res_ticks_next = echo_cnt_reg;
                res_to_next    = 1'b0;
                finished       = 1'b1;
            end
            else if (echo_cnt_reg != '1)
            begin
                echo_cnt_next = echo_cnt_reg + COUNT_WIDTH'(1);
            end

            if (!finished)
            begin
                if (tick_next != '1)
                begin
                    tick_next = tick_next + TICK_W'(1);
                end
                if (tick_next >= timeout_ticks)
                begin
                    res_ticks_next = '0;
                    res_to_next    = 1'b1;
                    finished       = 1'b1;
                end
            end

            if (finished)
            begin
                phase_next = PH_IDLE;
                tick_next  = '0;
                done       = 1'b1;
            end
        end
    end

    assign flags.trigger_level = trig;
    assign flags.busy_res      = (phase_next != PH_IDLE);
    assign flags.done_res      = done;
    assign flags.timed_out     = res_to_next;
    assign ticks               = res_ticks_next;

endmodule
`default_nettype wire

>>> rtl/uer_fifo.sv
// Short queue between front and back ends.
`default_nettype none
module uer_fifo #(
    parameter int unsigned WIDTH = 36,
    parameter int unsigned DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             rd,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wptr_reg, wptr_next;
    logic [AW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr & ~full;
    assign do_rd = rd & ~empty;
    assign rdata = mem[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

>>> rtl/uer_back.sv
// Back end: distance multiply pipeline and result output register.
`default_nettype none
module uer_back #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_empty,
    input  wire uer_pkg::uer_flags_t         q_flags,
    input  wire logic [COUNT_WIDTH-1:0]      q_ticks,
    output logic                             q_rd,
    input  wire logic [uer_pkg::SCALE_W-1:0] scale_factor,
    output uer_pkg::uer_result_t             result,
    output logic                             empty,
    input  wire logic                        pop
);
    import uer_pkg::*;

    localparam int unsigned HALF_W = PAD_W / 2;
    localparam int unsigned PROD_W = HALF_W + SCALE_W;
    localparam int unsigned SUM_W  = PROD_W + 1;
    localparam int unsigned SAT_B  = DIST_W + SCALE_W;

    logic               adv;
    logic [PAD_W-1:0]   ticks_pad;
    logic [SHOW_W-1:0]  shown;

    logic               va_reg;
    uer_flags_t         flags_a_reg;
    logic [SHOW_W-1:0]  show_a_reg;
    logic [PROD_W-1:0]  plo_a_reg, phi_a_reg;

    logic               vb_reg;
    uer_result_t        res_b_reg, res_b_next;

    logic [SUM_W-1:0]   sum;
    logic               sat;
    logic [DIST_W-1:0]  dist_val;

    assign adv       = ~vb_reg | pop;
    assign q_rd      = adv & ~q_empty;
    assign ticks_pad = PAD_W'(q_ticks);
    assign shown     = (|ticks_pad[PAD_W-1:SHOW_W]) ? '1 : ticks_pad[SHOW_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= ~q_empty;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flags_a_reg <= q_flags;
            show_a_reg  <= shown;
            plo_a_reg   <= PROD_W'(ticks_pad[HALF_W-1:0]) * PROD_W'(scale_factor);
            phi_a_reg   <= PROD_W'(ticks_pad[PAD_W-1:HALF_W]) * PROD_W'(scale_factor);
            res_b_reg   <= res_b_next;
        end
    end

    // product = phi * 2^24 + plo; saturate at 2^44
    assign sum      = SUM_W'({phi_a_reg[DIST_W-1:0], {SCALE_W{1'b0}}}) + SUM_W'(plo_a_reg);
    assign sat      = (|phi_a_reg[PROD_W-1:DIST_W]) | (|sum[SUM_W-1:SAT_B]);
    assign dist_val = sat ? '1 : sum[SAT_B-1:SCALE_W];

    always_comb
    begin
        res_b_next.trigger_level = flags_a_reg.trigger_level;
        res_b_next.busy_res      = flags_a_reg.busy_res;
        res_b_next.done_res      = flags_a_reg.done_res;
        res_b_next.timed_out     = flags_a_reg.timed_out;
        res_b_next.echo_ticks    = show_a_reg;
        res_b_next.distance_q8   = flags_a_reg.timed_out ? '0 : dist_val;
    end

    assign result = res_b_reg;
    assign empty  = ~vb_reg;

endmodule
`default_nettype wire

>>> rtl/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger.
//
// Input channel: one word per timer tick (start request in mode, sampled
// echo level), pushed with push while full is low. Every accepted word
// produces exactly one result word: trigger pin level, busy, done, timeout
// flag, last echo length and last distance in 1/256 cm.
// Result channel: the oldest result shows while empty is low and leaves on
// pop. Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Write only while the block is drained.
// Throughput: one word per cycle while full is low and the result channel
// is not stalled. A pushed word is written to the queue, read into the
// multiply stage, then into the output register before its result shows;
// the distance product is split into two 24x24 multiplies registered before
// the add and saturate.
// When pop is held low the back pipeline stalls, the 4-word queue fills,
// then full rises and no more ticks are taken.
// Reset: sequencer idle, counters and last result cleared, queue and
// pipeline empty, registers back to 3000 / 3000000 / 730144.
`default_nettype none
module ultrasonic_echo_ranger #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire uer_pkg::uer_item_t          item,
    input  wire logic                        push,
    output logic                             full,
    output uer_pkg::uer_result_t             result,
    output logic                             empty,
    input  wire logic                        pop,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [uer_pkg::CFG_AW-1:0]  cfg_index,
    input  wire logic [uer_pkg::CFG_DW-1:0]  cfg_data
);
    import uer_pkg::*;

    localparam int unsigned Q_W     = $bits(uer_flags_t) + COUNT_WIDTH;
    localparam int unsigned Q_DEPTH = 4;

    logic [TRIG_W-1:0]      trigger_ticks_reg;
    logic [TICK_W-1:0]      timeout_ticks_reg;
    logic [SCALE_W-1:0]     scale_factor_reg;

    logic                   accept;
    uer_flags_t             f_flags, q_flags;
    logic [COUNT_WIDTH-1:0] f_ticks, q_ticks;
    logic [Q_W-1:0]         q_rdata;
    logic                   q_empty, q_rd;

    assign cfg_ready = 1'b1;
    assign accept    = push & ~full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_ticks_reg <= TRIGGER_TICKS_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
            scale_factor_reg  <= SCALE_FACTOR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TRIGGER_TICKS: trigger_ticks_reg <= cfg_data[TRIG_W-1:0];
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[TICK_W-1:0];
                CFG_SCALE_FACTOR:  scale_factor_reg  <= cfg_data[SCALE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    uer_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .item         (item),
        .trigger_ticks(trigger_ticks_reg),
        .timeout_ticks(timeout_ticks_reg),
        .flags        (f_flags),
        .ticks        (f_ticks)
    );

    uer_fifo #(
        .WIDTH(Q_W),
        .DEPTH(Q_DEPTH)
    ) u_fifo (
        .clk  (clk),
        .rst_n(rst_n),
        .wr   (accept),
        .wdata({f_flags, f_ticks}),
        .full (full),
        .rd   (q_rd),
        .rdata(q_rdata),
        .empty(q_empty)
    );

    assign q_flags = q_rdata[Q_W-1:COUNT_WIDTH];
    assign q_ticks = q_rdata[COUNT_WIDTH-1:0];

    uer_back #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_flags     (q_flags),
        .q_ticks     (q_ticks),
        .q_rd        (q_rd),
        .scale_factor(scale_factor_reg),
        .result      (result),
        .empty       (empty),
        .pop         (pop)
    );

endmodule
`default_nettype wire

>>> rtl/uer_checker.sv
// Port checker for the ultrasonic echo ranger, bound to the top level.
`default_nettype none
module uer_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire uer_pkg::uer_result_t result,
    input wire logic                 empty,
    input wire logic                 pop
);
    import uer_pkg::*;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result word changed while stalled");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(result.done_res && result.busy_res))
        else $error("done word still busy");

    a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.trigger_level) |-> result.busy_res)
        else $error("trigger high while idle");

    a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.timed_out) |->
            (result.distance_q8 == '0 && result.echo_ticks == '0))
        else $error("timeout word carries a measurement");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .result(result),
    .empty (empty),
    .pop   (pop)
);
`default_nettype wire
